// ----- hdl/sha1_pkg.sv -----
// constants shared by the sha-1 hasher
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLOCK_W  = 512;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned DIG_WORDS = 5;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    // fill level at which the length field starts
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [2:0] MAX_BYTES = 3'd4;
    localparam logic [2:0] LAST_IDX  = 3'd4;
    localparam logic [6:0] LAST_ROUND = 7'd79;

endpackage

// ----- hdl/sha1_message_hasher_core.sv -----
// sha-1 hasher core: byte gathering, padding, iterative compression, digest out
`timescale 1ns / 1ps

// usage
//   input channel: i_valid / o_stall carry one transaction per message word
//   (i_data_word big-endian, i_byte_count 0..4, values above 4 act as 4,
//   i_end_of_message on the final word). output channel: o_valid / i_stall
//   carry the five digest words, o_word_index 0..4, o_last_word on the fifth.
// timing
//   o_stall is low only while the core is idle. after the accept cycle a
//   word's bytes go one byte per cycle into the block shift register,
//   paused while a block is compressed; an empty word has none. every
//   64th byte starts a compression: 80 rounds on the single round unit,
//   then the working variables fold into the chaining values one at a
//   time through one shared adder. on the final word padding and length go
//   in one byte per cycle, paused likewise (up to 64 bytes, 72 when an extra
//   block is needed), then the digest is offered one word per unstalled cycle.
// stall / reset
//   while i_stall is high the current digest word holds; the core stays
//   busy until the fifth word is taken, then reloads the initial chaining
//   values and clears the bit count. synchronous active-low reset puts the
//   core in idle with the initial chaining values and an empty block.
module sha1_message_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTES,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_FIN,
        S_OUT
    } t_state;

    t_state       r_state;
    t_state       r_resume;      // where to go once the block is compressed
    t_state       n_after_put;

    // block shift register, doubles as the message schedule window
    logic [511:0] r_blk;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [31:0]  r_word;
    logic [2:0]   r_cnt;
    logic         r_last;
    logic [6:0]   r_round;
    logic [2:0]   r_idx;
    logic [31:0]  r_h [sha1_pkg::DIG_WORDS];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;

    logic         put_en;
    logic [7:0]   put_byte;
    logic [5:0]   n_fill;
    logic [2:0]   in_cnt;
    logic [31:0]  rnd_f, rnd_k, rnd_t, w_cur, w_new, w_mix;

    assign in_cnt = (i_byte_count > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES : i_byte_count;
    assign n_fill = r_fill + 6'd1;

    // byte source and follow-on state for every byte-putting state
    always_comb begin
        put_en      = 1'b0;
        put_byte    = 8'h00;
        n_after_put = r_state;
        case (r_state)
            S_BYTES: begin
                put_en   = 1'b1;
                put_byte = r_word[31:24];
                if (r_cnt == 3'd1) begin
                    n_after_put = r_last ? S_PAD : S_IDLE;
                end else begin
                    n_after_put = S_BYTES;
                end
            end
            S_PAD, S_ZERO: begin
                put_en      = 1'b1;
                put_byte    = (r_state == S_PAD) ? sha1_pkg::PAD_BYTE : 8'h00;
                n_after_put = (n_fill == sha1_pkg::LEN_START) ? S_LEN : S_ZERO;
            end
            S_LEN: begin
                put_en      = 1'b1;
                put_byte    = r_bits[63:56];
                n_after_put = (r_fill == sha1_pkg::FILL_LAST) ? S_OUT : S_LEN;
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    // round unit: schedule tap and one sha-1 round
    always_comb begin
        w_cur = r_blk[511:480];
        w_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
        w_new = {w_mix[30:0], w_mix[31]};
        if (r_round < 7'd20) begin
            rnd_f = (r_b & r_c) | (~r_b & r_d);
            rnd_k = sha1_pkg::K_0;
        end else if (r_round < 7'd40) begin
            rnd_f = r_b ^ r_c ^ r_d;
            rnd_k = sha1_pkg::K_1;
        end else if (r_round < 7'd60) begin
            rnd_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            rnd_k = sha1_pkg::K_2;
        end else begin
            rnd_f = r_b ^ r_c ^ r_d;
            rnd_k = sha1_pkg::K_3;
        end
        rnd_t = {r_a[26:0], r_a[31:27]} + rnd_f + r_e + rnd_k + w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= S_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_round  <= '0;
            r_idx    <= '0;
            r_h[0]   <= sha1_pkg::H0_INIT;
            r_h[1]   <= sha1_pkg::H1_INIT;
            r_h[2]   <= sha1_pkg::H2_INIT;
            r_h[3]   <= sha1_pkg::H3_INIT;
            r_h[4]   <= sha1_pkg::H4_INIT;
        end else begin
            // common byte insertion path
            if (put_en) begin
                r_blk  <= {r_blk[503:0], put_byte};
                r_fill <= n_fill;
                if (r_fill == sha1_pkg::FILL_LAST) begin
                    r_state  <= S_COMP;
                    r_resume <= n_after_put;
                    r_round  <= '0;
                    r_a      <= r_h[0];
                    r_b      <= r_h[1];
                    r_c      <= r_h[2];
                    r_d      <= r_h[3];
                    r_e      <= r_h[4];
                end else begin
                    r_state <= n_after_put;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_word <= i_data_word;
                        r_cnt  <= in_cnt;
                        r_last <= i_end_of_message;
                        if (in_cnt != 3'd0) begin
                            r_state <= S_BYTES;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_BYTES: begin
                    r_word <= {r_word[23:0], 8'h00};
                    r_cnt  <= r_cnt - 3'd1;
                    r_bits <= r_bits + 64'd8;
                end
                S_LEN: begin
                    r_bits <= {r_bits[55:0], 8'h00};
                end
                S_COMP: begin
                    r_blk <= {r_blk[479:0], w_new};
                    r_a   <= rnd_t;
                    r_b   <= r_a;
                    r_c   <= {r_b[1:0], r_b[31:2]};
                    r_d   <= r_c;
                    r_e   <= r_d;
                    if (r_round == sha1_pkg::LAST_ROUND) begin
                        r_round <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                S_FIN: begin
                    // fold one working variable per cycle through the shared adder
                    r_h[0] <= r_h[1];
                    r_h[1] <= r_h[2];
                    r_h[2] <= r_h[3];
                    r_h[3] <= r_h[4];
                    r_h[4] <= r_h[0] + r_a;
                    r_a    <= r_b;
                    r_b    <= r_c;
                    r_c    <= r_d;
                    r_d    <= r_e;
                    r_e    <= r_a;
                    if (r_round == 7'(sha1_pkg::DIG_WORDS - 1)) begin
                        r_round <= '0;
                        r_state <= r_resume;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_idx == sha1_pkg::LAST_IDX) begin
                            r_idx   <= '0;
                            r_bits  <= '0;
                            r_state <= S_IDLE;
                            r_h[0]  <= sha1_pkg::H0_INIT;
                            r_h[1]  <= sha1_pkg::H1_INIT;
                            r_h[2]  <= sha1_pkg::H2_INIT;
                            r_h[3]  <= sha1_pkg::H3_INIT;
                            r_h[4]  <= sha1_pkg::H4_INIT;
                        end else begin
                            r_idx  <= r_idx + 3'd1;
                            r_h[0] <= r_h[1];
                            r_h[1] <= r_h[2];
                            r_h[2] <= r_h[3];
                            r_h[3] <= r_h[4];
                            r_h[4] <= r_h[0];
                        end
                    end
                end
                default: begin
                    // padding states are fully handled by the insertion path
                end
            endcase
        end
    end

    // ready only when idle; digest words come straight off the chaining registers
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[0];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == sha1_pkg::LAST_IDX);

`ifndef ASSERT_OFF
    // never ready for input while a digest is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while digest pending");

    // last flag tracks the word index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == sha1_pkg::LAST_IDX)))
        else $error("last_word out of step with word_index");

    // after the fifth word is taken the core is idle again
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> !o_stall)
        else $error("core not idle after digest");

    // a digest word starts at index zero
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == 3'd0))
        else $error("digest did not start at word zero");
`endif

endmodule

// ----- dv/sha1_digest_checker.sv -----
// digest checker: watches both channels of the sha-1 core, predicts and compares digests
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_end_of_message,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_mismatch_count,
    output int          o_pending_digests
);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;
    localparam logic [31:0] RK_0 = 32'h5A827999;
    localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK_3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK     = 8'h80;
    localparam int          LENGTH_AT    = 56;
    localparam int          BLOCK_BYTES  = 64;
    localparam logic [2:0]  MAX_COUNT    = 3'd4;
    localparam int          DIGEST_WORDS = 5;
    localparam logic [2:0]  FINAL_INDEX  = 3'd4;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_entry_t;

    logic [31:0]   hash_state [DIGEST_WORDS];
    logic [7:0]    block_bytes [BLOCK_BYTES];
    int            block_fill;
    logic [63:0]   bit_length;
    digest_entry_t digest_q [$];
    digest_entry_t expected;
    int            mismatches = 0;
    int            pending = 0;

    assign o_mismatch_count  = mismatches;
    assign o_pending_digests = pending;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_hash();
        hash_state[0] = IV_A;
        hash_state[1] = IV_B;
        hash_state[2] = IV_C;
        hash_state[3] = IV_D;
        hash_state[4] = IV_E;
        block_fill = 0;
        bit_length = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        for (r = 16; r < 80; r++) begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_2;
            end else begin
                f = b ^ c ^ d;
                k = RK_3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endtask

    task automatic push_byte(input logic [7:0] v);
        block_bytes[block_fill] = v;
        block_fill++;
        if (block_fill == BLOCK_BYTES) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // absorb one message word; on the final word pad, finish and queue the digest
    task automatic absorb_word(input logic [31:0] data, input logic [2:0] count,
                               input logic eom);
        int            n;
        int            i;
        logic [63:0]   total;
        digest_entry_t ent;
        n = int'((count > MAX_COUNT) ? MAX_COUNT : count);
        for (i = 0; i < n; i++) begin
            push_byte(8'((data >> (24 - 8 * i)) & 32'hFF));
            bit_length += 64'd8;
        end
        if (eom) begin
            total = bit_length;
            push_byte(PAD_MARK);
            while (block_fill != LENGTH_AT) push_byte(8'h00);
            for (i = 0; i < 8; i++) push_byte(8'((total >> (56 - 8 * i)) & 64'hFF));
            for (i = 0; i < DIGEST_WORDS; i++) begin
                ent.digest_word = hash_state[i];
                ent.word_index  = 3'(i);
                ent.last_word   = (3'(i) == FINAL_INDEX);
                digest_q.push_back(ent);
            end
            restart_hash();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest transaction with nothing expected: word %h index %0d",
                           i_digest_word, i_word_index);
                    mismatches++;
                end else begin
                    expected = digest_q.pop_front();
                    if (i_digest_word !== expected.digest_word) begin
                        $error("digest_word: expected %h, actual %h",
                               expected.digest_word, i_digest_word);
                        mismatches++;
                    end
                    if (i_word_index !== expected.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               expected.word_index, i_word_index);
                        mismatches++;
                    end
                    if (i_last_word !== expected.last_word) begin
                        $error("last_word: expected %b, actual %b",
                               expected.last_word, i_last_word);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_word(i_data_word, i_byte_count, i_end_of_message);
            end
        end
        pending = digest_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
// testbench top: stimulus, stall generation and verdict for the sha-1 hasher core
`timescale 1ns / 1ps

module testbench;

    // generous ceiling, far above the slowest legal run
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 300;
    // the last stretch runs with no idling on either side
    localparam int QUIET_ITEMS  = 60;
    // after the queue empties, give the core time to settle
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int mismatch_count;
    int pending_digests;
    int cycle_count = 0;
    int words_sent  = 0;
    bit quiet_tail  = 1'b0;

    sha1_message_hasher_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    sha1_digest_checker u_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_data_word       (i_data_word),
        .i_byte_count      (i_byte_count),
        .i_end_of_message  (i_end_of_message),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_digest_word     (o_digest_word),
        .i_word_index      (o_word_index),
        .i_last_word       (o_last_word),
        .o_mismatch_count  (mismatch_count),
        .o_pending_digests (pending_digests)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sha1_message_hasher_core regression: fail");
            $finish;
        end
    end

    // digest-side back-pressure: random bursts of stall and of free flow,
    // switched off for the quiet tail
    initial begin : stall_gen
        int span;
        i_stall = 1'b0;
        forever begin
            span = $urandom_range(1, 15);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
            repeat (span) @(negedge i_clk);
        end
    end

    // one input transaction: called just after a falling edge, holds the payload
    // until the core takes it, then may idle the channel for a random burst
    task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                             input logic eom);
        i_data_word      = data;
        i_byte_count     = count;
        i_end_of_message = eom;
        i_valid          = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // an empty word without end of message is ignored by the core
        if (count != 3'd0 || eom) words_sent++;
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    // one whole message: mostly full words, now and then a short, empty or
    // oversized count mid-message, and a final word of 0 to 4 bytes
    task automatic send_message(input int nwords);
        int          i;
        logic [2:0]  count;
        for (i = 0; i < nwords; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                count = 3'($urandom_range(0, 7));
            end else begin
                count = 3'd4;
            end
            send_word($urandom, count, 1'b0);
        end
        if ($urandom_range(0, 7) == 0) begin
            count = 3'($urandom_range(5, 7));
        end else begin
            count = 3'($urandom_range(0, 4));
        end
        send_word($urandom, count, 1'b1);
    endtask

    initial begin : stimulus
        int i;
        int target;
        int pick;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_data_word      = '0;
        i_byte_count     = '0;
        i_end_of_message = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, the hash of ""
        send_word(32'h0000_0000, 3'd0, 1'b1);
        // "abc" with a junk low byte that must be ignored
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        // oversized counts act as four bytes; an empty word mid-message is a no-op
        send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
        send_word(32'h0000_0000, 3'd5, 1'b0);
        send_word(32'hDEAD_BEEF, 3'd0, 1'b0);
        send_word(32'h8000_0001, 3'd6, 1'b1);
        // one- and two-byte words before a full final word
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word(32'h9ABC_DEF0, 3'd2, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        // 56 bytes: padding spills into an extra block, closed by an empty final word
        for (i = 0; i < 14; i++) send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd0, 1'b1);

        // random messages: short ones, ones near the padding boundary, a few long
        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target) begin
            if (target - words_sent <= QUIET_ITEMS) quiet_tail = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                send_message($urandom_range(0, 8));
            end else if (pick <= 8) begin
                send_message($urandom_range(13, 17));
            end else begin
                send_message($urandom_range(30, 40));
            end
        end
        quiet_tail = 1'b1;
        i_valid    = 1'b0;

        // wait for every expected digest word, then let the core settle
        while (pending_digests != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sha1_message_hasher_core regression: pass");
        end else begin
            $display("sha1_message_hasher_core regression: fail");
        end
        $finish;
    end

endmodule
